[hdl/fdt_pkg.sv]
`default_nettype none

package fdt_pkg;

  // Float field layout
  localparam int unsigned FLOAT_W = 32;
  localparam int unsigned EXP_W   = 8;
  localparam int unsigned MAN_W   = 23;
  localparam int unsigned SIG_W   = MAN_W + 1;

  localparam logic [EXP_W-1:0] EXP_ZERO    = 8'h00;
  localparam logic [EXP_W-1:0] EXP_SPECIAL = 8'hFF;
  // Exponent at which the significand is an integer with no fraction bits
  localparam logic [EXP_W-1:0] EXP_INT_MIN = 8'd150;
  // Left shifts at or above this overflow the integer part
  localparam int unsigned SAT_SHIFT = 8;

  // Integer part and its decimal form
  localparam int unsigned INT_W      = 31;
  localparam int unsigned INT_DIGITS = 10;
  localparam int unsigned LEAD_W     = $clog2(INT_DIGITS);
  localparam logic [INT_W-1:0] SAT_VALUE = 31'h7FFF_FFFF;

  // Exact binary fraction, processed one limb per cycle
  localparam int unsigned FRAC_W     = 160;
  localparam int unsigned LIMB_W     = 80;
  localparam int unsigned N_LIMBS    = FRAC_W / LIMB_W;
  localparam int unsigned LIMB_CNT_W = (N_LIMBS > 1) ? $clog2(N_LIMBS) : 1;
  localparam int unsigned DIGIT_W    = 4;

  // Configuration
  localparam int unsigned CFG_W = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd6;
  localparam int unsigned MAX_FRACTION_DIGITS_DEF = 9;

  // Output characters
  localparam int unsigned CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;

  typedef logic [INT_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  // Decoded operand handed to the conversion units
  typedef struct packed {
    logic              neg;
    logic [INT_W-1:0]  ipart;
    logic [FRAC_W-1:0] frac;
  } decode_t;

  // Fraction unit control
  typedef struct packed {
    logic load;
    logic step;
    logic first;
  } frac_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    digit_char = CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
  endfunction

endpackage

`default_nettype wire

[hdl/fdt_intf.sv]
`default_nettype none

// Float operand request channel
interface fdt_in_if import fdt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FLOAT_W-1:0] float_bits;

  modport source (output valid, output float_bits, input ready);
  modport sink   (input valid, input float_bits, output ready);
endinterface

// Character result channel
interface fdt_out_if import fdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_character;

  modport source (output valid, output character, output last_character, input ready);
  modport sink   (input valid, input character, input last_character, output ready);
endinterface

// Fraction digit count write channel
interface fdt_cfg_if import fdt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] fraction_digits;

  modport source (output valid, output fraction_digits, input ready);
  modport sink   (input valid, input fraction_digits, output ready);
endinterface

`default_nettype wire

[hdl/float_to_decimal_text.sv]
// Sequence: accept, binary-to-decimal conversion (31 shifts, then a check that it has
// finished), find the leading digit, then emit the sign if negative, each integer digit
// and the point; each fraction digit takes two limb passes of the times-ten unit and one
// emit. Output stalls lengthen a number.
// Throughput: one number at a time; the next request is taken once the last
// character is in the output register. Reset clears the sequencer, the output
// valid and sets the fraction digit count to 6.
`default_nettype none

module float_to_decimal_text import fdt_pkg::*; #(
  parameter int unsigned MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  fdt_cfg_if.sink          cfg_i,
  fdt_in_if.sink           in_i,
  fdt_out_if.source        out_o
);

  localparam int unsigned NF_W = $clog2(MAX_FRACTION_DIGITS + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CONV  = 8'b0000_0010,
    S_LEAD  = 8'b0000_0100,
    S_SIGN  = 8'b0000_1000,
    S_INT   = 8'b0001_0000,
    S_POINT = 8'b0010_0000,
    S_MUL   = 8'b0100_0000,
    S_FOUT  = 8'b1000_0000
  } state_e;

  state_e                 state_q, state_d;
  logic [CFG_W-1:0]       cfg_q;
  logic [NF_W-1:0]        nf_q, nf_d;
  logic [NF_W-1:0]        k_q, k_d;
  logic [LEAD_W-1:0]      idx_q, idx_d;
  logic [LIMB_CNT_W-1:0]  limb_q, limb_d;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      char_q, char_d;
  logic                   last_q, last_d;

  decode_t                dec;
  logic                   bcd_load;
  logic                   bcd_done;
  bcd_t                   bcd;
  logic [LEAD_W-1:0]      bcd_lead;
  frac_ctrl_t             frac_ctrl;
  logic [DIGIT_W-1:0]     frac_digit;

  logic                   emit_ok;
  logic                   emit;
  logic [CHAR_W-1:0]      emit_char;
  logic                   emit_last;

  fdt_unpack u_unpack (
    .float_bits_i (in_i.float_bits),
    .dec_o        (dec)
  );

  fdt_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (bcd_load),
    .ipart_i (dec.ipart),
    .done_o  (bcd_done),
    .bcd_o   (bcd),
    .lead_o  (bcd_lead)
  );

  fdt_frac u_frac (
    .clk_i   (clk_i),
    .ctrl_i  (frac_ctrl),
    .frac_i  (dec.frac),
    .digit_o (frac_digit)
  );

  // Configuration register is always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      cfg_q <= cfg_i.fraction_digits;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign emit_ok    = !out_valid_q || out_o.ready;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    nf_d      = nf_q;
    k_d       = k_q;
    idx_d     = idx_q;
    limb_d    = limb_q;
    neg_d     = neg_q;
    bcd_load  = 1'b0;
    frac_ctrl = '0;
    emit      = 1'b0;
    emit_char = CH_ZERO;
    emit_last = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          bcd_load       = 1'b1;
          frac_ctrl.load = 1'b1;
          neg_d          = dec.neg;
          if ({{(32-CFG_W){1'b0}}, cfg_q} > 32'(MAX_FRACTION_DIGITS)) begin
            nf_d = NF_W'(MAX_FRACTION_DIGITS);
          end else begin
            nf_d = NF_W'(cfg_q);
          end
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          state_d = S_LEAD;
        end
      end
      S_LEAD: begin
        idx_d   = bcd_lead;
        state_d = neg_q ? S_SIGN : S_INT;
      end
      S_SIGN: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_char = CH_MINUS;
          state_d   = S_INT;
        end
      end
      S_INT: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_char = digit_char(bcd[idx_q]);
          emit_last = (idx_q == '0) && (nf_q == '0);
          if (idx_q == '0) begin
            state_d = (nf_q != '0) ? S_POINT : S_IDLE;
          end else begin
            idx_d = idx_q - LEAD_W'(1);
          end
        end
      end
      S_POINT: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_char = CH_POINT;
          k_d       = '0;
          limb_d    = '0;
          state_d   = S_MUL;
        end
      end
      S_MUL: begin
        frac_ctrl.step  = 1'b1;
        frac_ctrl.first = (limb_q == '0);
        if (limb_q == LIMB_CNT_W'(N_LIMBS-1)) begin
          limb_d  = '0;
          state_d = S_FOUT;
        end else begin
          limb_d = limb_q + LIMB_CNT_W'(1);
        end
      end
      S_FOUT: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_char = digit_char(frac_digit);
          emit_last = (k_q == (nf_q - NF_W'(1)));
          if (emit_last) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + NF_W'(1);
            state_d = S_MUL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: load on emit, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      char_d      = emit_char;
      last_d      = emit_last;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      limb_q      <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      limb_q      <= limb_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nf_q   <= nf_d;
    idx_q  <= idx_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.character      = char_q;
  assign out_o.last_character = last_q;

endmodule

`default_nettype wire

[hdl/fdt_unpack.sv]
`default_nettype none

module fdt_unpack import fdt_pkg::*; (
  input  logic [FLOAT_W-1:0] float_bits_i,
  output decode_t            dec_o
);

  logic [EXP_W-1:0]        ex;
  logic [SIG_W-1:0]        sig;
  logic [EXP_W-1:0]        lsh;
  logic [EXP_W-1:0]        rsh;
  logic [INT_W-1:0]        sig_ext;
  logic [SIG_W-1:0]        sig_shr;
  logic [SIG_W+FRAC_W-1:0] wide;

  // Split the pattern into integer part and exact binary fraction
  always_comb begin
    ex      = float_bits_i[FLOAT_W-2 -: EXP_W];
    sig     = {1'b1, float_bits_i[MAN_W-1:0]};
    lsh     = ex - EXP_INT_MIN;
    rsh     = EXP_INT_MIN - ex;
    sig_ext = {{(INT_W-SIG_W){1'b0}}, sig};
    sig_shr = sig >> rsh;
    wide    = {sig, {FRAC_W{1'b0}}} >> rsh;

    dec_o.neg   = float_bits_i[FLOAT_W-1] && (ex != EXP_ZERO);
    dec_o.ipart = '0;
    dec_o.frac  = '0;

    if (ex == EXP_SPECIAL) begin
      dec_o.ipart = SAT_VALUE;
    end else if (ex == EXP_ZERO) begin
      dec_o.ipart = '0;
    end else if (ex >= EXP_INT_MIN) begin
      if (lsh >= EXP_W'(SAT_SHIFT)) begin
        dec_o.ipart = SAT_VALUE;
      end else begin
        dec_o.ipart = sig_ext << lsh[2:0];
      end
    end else begin
      // Significand bits above the fixed-point width form the integer part
      if (rsh < EXP_W'(SIG_W)) begin
        dec_o.ipart = {{(INT_W-SIG_W){1'b0}}, sig_shr};
      end
      dec_o.frac = wide[FRAC_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/fdt_bcd.sv]
`default_nettype none

module fdt_bcd import fdt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [INT_W-1:0]  ipart_i,
  output logic              done_o,
  output bcd_t              bcd_o,
  output logic [LEAD_W-1:0] lead_o
);

  localparam int unsigned CNT_W = $clog2(INT_W);

  logic [INT_W-1:0] bin_q;
  bcd_t             bcd_q;
  bcd_t             bcd_adj;
  logic [INT_DIGITS*DIGIT_W-1:0] adj_flat;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (bcd_q[i] >= DIGIT_W'(5)) begin
        bcd_adj[i] = bcd_q[i] + DIGIT_W'(3);
      end else begin
        bcd_adj[i] = bcd_q[i];
      end
    end
  end

  assign adj_flat = bcd_adj;

  // Sequence control: one binary bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (load_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(INT_W-1)) begin
        run_q <= 1'b0;
      end
    end
  end

  // Shift the binary value into the decimal digits
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bin_q <= ipart_i;
      bcd_q <= '0;
    end else if (run_q) begin
      bin_q <= {bin_q[INT_W-2:0], 1'b0};
      bcd_q <= {adj_flat[INT_DIGITS*DIGIT_W-2:0], bin_q[INT_W-1]};
    end
  end

  // Find the most significant nonzero digit
  always_comb begin
    lead_o = '0;
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (bcd_q[i] != '0) begin
        lead_o = LEAD_W'(i);
      end
    end
  end

  assign done_o = !run_q;
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

[hdl/fdt_frac.sv]
`default_nettype none

module fdt_frac import fdt_pkg::*; (
  input  logic               clk_i,
  input  frac_ctrl_t         ctrl_i,
  input  logic [FRAC_W-1:0]  frac_i,
  output logic [DIGIT_W-1:0] digit_o
);

  logic [FRAC_W-1:0]       frac_q;
  logic [DIGIT_W-1:0]      carry_q;
  logic [DIGIT_W-1:0]      cin;
  logic [LIMB_W+DIGIT_W-1:0] prod;

  // Multiply the low limb by ten and add the carry of the limb below
  always_comb begin
    cin  = ctrl_i.first ? '0 : carry_q;
    prod = {1'b0, frac_q[LIMB_W-1:0], 3'b000}
         + {3'b000, frac_q[LIMB_W-1:0], 1'b0}
         + {{LIMB_W{1'b0}}, cin};
  end

  // Rotate limbs so the next one lands at the bottom
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      frac_q  <= frac_i;
      carry_q <= '0;
    end else if (ctrl_i.step) begin
      frac_q  <= {prod[LIMB_W-1:0], frac_q[FRAC_W-1:LIMB_W]};
      carry_q <= prod[LIMB_W+DIGIT_W-1:LIMB_W];
    end
  end

  // Carry out of the top limb is the next decimal digit
  assign digit_o = carry_q;

endmodule

`default_nettype wire

[hdl/fdt_checker.sv]
`default_nettype none

module fdt_checker import fdt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CHAR_W-1:0] character_i,
  input  logic              last_character_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(character_i) && $stable(last_character_i))
    else $error("stalled result changed");

  // Only sign, point and digit characters leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (character_i == CH_MINUS) || (character_i == CH_POINT) ||
                    ((character_i >= CH_ZERO) && (character_i <= CH_ZERO + 7'd9)))
    else $error("illegal character");

  // A new request is not taken while a conversion runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted during conversion");

endmodule

bind float_to_decimal_text fdt_checker u_fdt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .character_i      (out_o.character),
  .last_character_i (out_o.last_character)
);

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import fdt_pkg::*;

  localparam int unsigned MAX_DIGITS = MAX_FRACTION_DIGITS_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES = 80;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n;

  fdt_cfg_if digits_if ();
  fdt_in_if  float_if ();
  fdt_out_if text_if ();

  float_to_decimal_text i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (digits_if),
    .in_i   (float_if),
    .out_o  (text_if)
  );

  // Expected characters, oldest first
  text_char_t text_q[$];
  logic [CFG_W-1:0] digit_count = CFG_RESET;
  int mismatches = 0;
  // Set by the tests: no idle cycles on either side while high
  bit steady = 1'b0;
  // Receiver hold-off length requested by a test
  int hold_request = 0;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive known values from time zero, then run reset
  initial begin
    rst_n = 1'b0;
    float_if.valid = 1'b0;
    float_if.float_bits = '0;
    digits_if.valid = 1'b0;
    digits_if.fraction_digits = '0;
    text_if.ready = 1'b0;
  end

  // Bound the run
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // Push the characters one float is expected to produce
  function automatic void predict_text(input logic [FLOAT_W-1:0] bits);
    logic [EXP_W-1:0] ex;
    logic [SIG_W-1:0] sig;
    logic [SIG_W-1:0] fbits;
    logic [INT_W-1:0] ipart;
    logic [FRAC_W-1:0] frac;
    logic [FRAC_W+3:0] prod;
    logic [DIGIT_W-1:0] digs[INT_DIGITS];
    logic [CFG_W-1:0] ndig;
    logic neg;
    text_char_t ch;
    int shift;
    int nd;
    ex = bits[FLOAT_W-2 -: EXP_W];
    sig = {1'b1, bits[MAN_W-1:0]};
    neg = bits[FLOAT_W-1] && (ex != EXP_ZERO);
    ipart = '0;
    frac = '0;
    fbits = '0;
    ndig = (digit_count > MAX_DIGITS) ? CFG_W'(MAX_DIGITS) : digit_count;

    // Split into integer part and exact binary fraction
    if (ex == EXP_SPECIAL) begin
      ipart = SAT_VALUE;
    end else if (ex != EXP_ZERO) begin
      if (ex >= EXP_INT_MIN) begin
        shift = int'(ex) - int'(EXP_INT_MIN);
        ipart = (shift >= SAT_SHIFT) ? SAT_VALUE : (INT_W'(sig) << shift);
      end else begin
        shift = int'(EXP_INT_MIN) - int'(ex);
        if (shift >= SIG_W) begin
          fbits = sig;
        end else begin
          ipart = INT_W'(sig >> shift);
          fbits = sig & ((SIG_W'(1) << shift) - SIG_W'(1));
        end
        frac = FRAC_W'(fbits) << (FRAC_W - shift);
      end
    end

    ch.last = 1'b0;
    if (neg) begin
      ch.code = CH_MINUS;
      text_q.push_back(ch);
    end

    // Integer digits, least significant first, then emit in reverse
    nd = 0;
    do begin
      digs[nd] = DIGIT_W'(ipart % 10);
      ipart = INT_W'(ipart / 10);
      nd++;
    end while (ipart != 0 && nd < INT_DIGITS);
    for (int i = nd - 1; i >= 0; i--) begin
      ch.code = CH_ZERO + CHAR_W'(digs[i]);
      text_q.push_back(ch);
    end

    // Fraction digits are the carries out of a multiply by ten
    if (ndig != 0) begin
      ch.code = CH_POINT;
      text_q.push_back(ch);
      for (int k = 0; k < ndig; k++) begin
        prod = ({4'b0, frac} << 3) + ({4'b0, frac} << 1);
        frac = prod[FRAC_W-1:0];
        ch.code = CH_ZERO + CHAR_W'(prod[FRAC_W+3:FRAC_W]);
        text_q.push_back(ch);
      end
    end
    text_q[text_q.size()-1].last = 1'b1;
  endfunction

  // Random float, weighted toward exponents with both integer and fraction bits
  function automatic logic [FLOAT_W-1:0] rand_float();
    logic [EXP_W-1:0] ex;
    logic [FLOAT_W-1:0] bits;
    bits = $urandom;
    case ($urandom_range(9))
      0, 1: ex = bits[FLOAT_W-2 -: EXP_W];
      2, 3, 4, 5, 6: ex = EXP_W'($urandom_range(110, 157));
      7: ex = EXP_W'($urandom_range(1, 109));
      8: ex = $urandom_range(1) ? EXP_SPECIAL : EXP_ZERO;
      default: ex = EXP_W'($urandom_range(148, 160));
    endcase
    bits[FLOAT_W-2 -: EXP_W] = ex;
    return bits;
  endfunction

  // Offer one float and predict its text once accepted
  task automatic send_float(input logic [FLOAT_W-1:0] bits);
    int gap;
    gap = (!steady && $urandom_range(99) < 16) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      float_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    float_if.valid <= 1'b1;
    float_if.float_bits <= bits;
    do @(posedge clk); while (!float_if.ready);
    predict_text(bits);
  endtask

  // Drop the request and wait until every expected character has come
  task automatic wait_results();
    @(negedge clk);
    float_if.valid <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the digit count; only called while the block is idle
  task automatic write_digits(input logic [CFG_W-1:0] value);
    @(negedge clk);
    digits_if.valid <= 1'b1;
    digits_if.fraction_digits <= value;
    do @(posedge clk); while (!digits_if.ready);
    digit_count = value;
    @(negedge clk);
    digits_if.valid <= 1'b0;
  endtask

  // Receiver: random stalls, or a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      text_if.ready <= 1'b0;
      hold_left--;
    end else if (steady) begin
      text_if.ready <= 1'b1;
    end else begin
      text_if.ready <= ($urandom_range(99) >= 16);
    end
  end

  // Compare each accepted character with the oldest expectation
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && text_if.valid && text_if.ready) begin
      if (text_q.size() == 0) begin
        $error("character: expected none, actual %h", text_if.character);
        mismatches++;
      end else begin
        want = text_q.pop_front();
        if (text_if.character !== want.code) begin
          $error("character: expected %h, actual %h", want.code, text_if.character);
          mismatches++;
        end
        if (text_if.last_character !== want.last) begin
          $error("last_character: expected %b, actual %b", want.last,
                 text_if.last_character);
          mismatches++;
        end
      end
    end
  end

  // Default digit count with zeros, subnormals, limits and specials
  task automatic test_special_values();
    logic [FLOAT_W-1:0] vals[$];
    vals = {32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
            32'h0080_0000, 32'h8080_0000, 32'h3F80_0000, 32'hBFC0_0000,
            32'h3DCC_CCCD, 32'h3F7F_FFFF, 32'h3F00_0000, 32'h42F6_E979,
            32'h4B00_0000, 32'h4B7F_FFFF, 32'h4EFF_FFFF, 32'h4F00_0000,
            32'h7F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
            32'hFFFF_FFFF};
    foreach (vals[i]) send_float(vals[i]);
    wait_results();
  endtask

  // Walk the digit count through its extremes, clamped values included
  task automatic test_digit_counts();
    logic [CFG_W-1:0] counts[$];
    counts = {4'd0, 4'd1, 4'd9, 4'd10, 4'd15, 4'd3};
    foreach (counts[i]) begin
      write_digits(counts[i]);
      send_float(32'h3DCC_CCCD);
      repeat (4) send_float(rand_float());
      wait_results();
    end
  endtask

  // Hold the receiver off while floats keep coming, so the input stalls
  task automatic test_backpressure();
    hold_request = 300;
    repeat (6) send_float(rand_float());
    wait_results();
    // Sender pauses for a full drain between bursts
    repeat (3) begin
      repeat (4) send_float(rand_float());
      wait_results();
    end
  endtask

  // Random floats over several digit counts, one phase with no idling
  task automatic test_random_floats();
    for (int phase = 0; phase < 5; phase++) begin
      write_digits(CFG_W'($urandom_range(15)));
      steady = (phase == 2);
      repeat (76) send_float(rand_float());
      wait_results();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_special_values();
    test_digit_counts();
    test_backpressure();
    test_random_floats();

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && text_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
